// ===== design/lru_key_value_cache_unit_defines.svh =====
// Assertion macros shared by the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define LKV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst is high.
`define LKV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lkv_pkg.sv =====
// Shared command and status types for the LRU key-value cache.
package lkv_pkg;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOOKUP,
    OP_DECIDE,
    OP_UNLINK,
    OP_READ_TAIL,
    OP_LINK_A,
    OP_LINK_B,
    OP_SELF,
    OP_EVICT_A,
    OP_EVICT_B,
    OP_FINISH,
    OP_REPORT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hit;
    logic is_head;
    logic is_put;
    logic alloc_ok;
    logic head_valid;
  } dp_status_t;

endpackage

// ===== design/lkv_ctrl.sv =====
// Sequencer for the LRU key-value cache: one beat at a time.
`include "lru_key_value_cache_unit_defines.svh"

module lkv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  output lkv_pkg::dp_cmd_t    cmd,
  input  lkv_pkg::dp_status_t status
);
  import lkv_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_UNLINK,
    S_READ_TAIL,
    S_LINK_A,
    S_LINK_B,
    S_SELF,
    S_EVICT_A,
    S_EVICT_B,
    S_FINISH,
    S_REPORT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOOKUP;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.op = OP_DECIDE;
        if (status.hit) begin
          state_next = status.is_head ? S_FINISH : S_UNLINK;
        end else if (!status.is_put) begin
          state_next = S_REPORT;
        end else if (status.alloc_ok) begin
          state_next = status.head_valid ? S_LINK_A : S_SELF;
        end else begin
          state_next = S_EVICT_A;
        end
      end
      S_UNLINK: begin
        cmd.op     = OP_UNLINK;
        state_next = S_READ_TAIL;
      end
      S_READ_TAIL: begin
        cmd.op     = OP_READ_TAIL;
        state_next = S_LINK_A;
      end
      S_LINK_A: begin
        cmd.op     = OP_LINK_A;
        state_next = S_LINK_B;
      end
      S_LINK_B: begin
        cmd.op     = OP_LINK_B;
        state_next = S_FINISH;
      end
      S_SELF: begin
        cmd.op     = OP_SELF;
        state_next = S_FINISH;
      end
      S_EVICT_A: begin
        cmd.op     = OP_EVICT_A;
        state_next = S_EVICT_B;
      end
      S_EVICT_B: begin
        cmd.op     = OP_EVICT_B;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.op     = OP_FINISH;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        cmd.op     = OP_REPORT;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_REPORT);

  `LKV_ASSERT_NXT(a_done_single, done, !done, "result strobe held for more than one cycle")
  `LKV_ASSERT_IMP(a_done_busy, done, busy, "result strobe while idle")
  `LKV_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted beat did not raise busy")

endmodule

// ===== design/lkv_datapath.sv =====
// Key map, entry store and recency links of the LRU key-value cache.
`include "lru_key_value_cache_unit_defines.svh"

module lkv_datapath #(
  parameter int ENTRIES    = 4096,
  parameter int KEY_SPACE  = 16384,
  parameter int VALUE_BITS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  lkv_pkg::dp_cmd_t    cmd,
  output lkv_pkg::dp_status_t status,
  input  logic                opcode,
  input  logic [13:0]         key,
  input  logic [16:0]         value,
  input  logic                cfg_valid,
  input  logic [12:0]         cfg_data,
  output logic                found,
  output logic [16:0]         read_value
);
  import lkv_pkg::*;

  localparam int SW = $clog2(ENTRIES);
  localparam int KB = $clog2(KEY_SPACE);
  localparam int UW = SW + 1;

  // memories
  logic [SW:0]            km_mem [KEY_SPACE];
  logic [KB-1:0]          ek_mem [ENTRIES];
  logic [VALUE_BITS-1:0]  ev_mem [ENTRIES];
  logic [SW-1:0]          ol_mem [ENTRIES];
  logic [SW-1:0]          nl_mem [ENTRIES];

  logic [SW:0]            km_rd;
  logic [KB-1:0]          ek_rd;
  logic [VALUE_BITS-1:0]  ev_rd;
  logic [SW-1:0]          ol_rd;
  logic [SW-1:0]          nl_rd;

  // control and working registers
  logic                   op_put;
  logic [KB-1:0]          key_q;
  logic [VALUE_BITS-1:0]  val_q;
  logic                   hit_q;
  logic [SW-1:0]          slot_q;
  logic [SW-1:0]          tail_q;
  logic [SW-1:0]          head;
  logic                   head_valid;
  logic [UW-1:0]          used;
  logic [12:0]            capacity;
  logic [KB-1:0]          clr_cnt;

  logic [31:0]            key_w;
  logic [31:0]            val_w;
  logic [31:0]            rv_w;
  logic [31:0]            cap_w;
  logic [31:0]            cap_eff;
  logic [KB-1:0]          key_idx;
  logic                   km_hit;
  logic [SW-1:0]          km_slot;
  logic                   alloc_ok;

  logic                   km_we;
  logic [KB-1:0]          km_wa;
  logic [SW:0]            km_wd;
  logic                   ol_we;
  logic [SW-1:0]          ol_wa;
  logic [SW-1:0]          ol_wd;
  logic                   nl_we;
  logic [SW-1:0]          nl_wa;
  logic [SW-1:0]          nl_wd;
  logic                   ent_we;
  logic [SW-1:0]          nl_ra;

  assign key_w   = 32'(key);
  assign key_idx = key_w[KB-1:0];
  assign val_w   = 32'(value);
  assign km_hit  = km_rd[SW];
  assign km_slot = km_rd[SW-1:0];

  // capacity zero acts as one, above ENTRIES acts as ENTRIES
  assign cap_w   = 32'(capacity);
  assign cap_eff = (cap_w == 32'd0) ? 32'd1 :
                   (cap_w > 32'(ENTRIES)) ? 32'(ENTRIES) : cap_w;
  assign alloc_ok = (32'(used) < cap_eff) || !head_valid;

  assign status.clear_last = (clr_cnt == {KB{1'b1}});
  assign status.hit        = km_hit;
  assign status.is_head    = head_valid && (head == km_slot);
  assign status.is_put     = op_put;
  assign status.alloc_ok   = alloc_ok;
  assign status.head_valid = head_valid;

  assign nl_ra = ((cmd.op == OP_DECIDE) && km_hit) ? km_slot : head;

  always_comb begin
    km_we  = 1'b0;
    km_wa  = key_q;
    km_wd  = {1'b1, slot_q};
    ol_we  = 1'b0;
    ol_wa  = slot_q;
    ol_wd  = slot_q;
    nl_we  = 1'b0;
    nl_wa  = slot_q;
    nl_wd  = slot_q;
    ent_we = 1'b0;
    case (cmd.op)
      OP_CLEAR: begin
        km_we = 1'b1;
        km_wa = clr_cnt;
        km_wd = '0;
      end
      OP_UNLINK: begin
        ol_we = 1'b1;
        ol_wa = nl_rd;
        ol_wd = ol_rd;
        nl_we = 1'b1;
        nl_wa = ol_rd;
        nl_wd = nl_rd;
      end
      OP_LINK_A: begin
        nl_we = 1'b1;
        nl_wd = nl_rd;
        ol_we = 1'b1;
        ol_wd = head;
      end
      OP_LINK_B: begin
        nl_we = 1'b1;
        nl_wa = head;
        ol_we = 1'b1;
        ol_wa = tail_q;
      end
      OP_SELF: begin
        nl_we = 1'b1;
        ol_we = 1'b1;
      end
      OP_EVICT_B: begin
        km_we = 1'b1;
        km_wa = ek_rd;
        km_wd = '0;
      end
      OP_FINISH: begin
        km_we  = op_put;
        ent_we = op_put;
      end
      default: begin
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    km_rd <= km_mem[key_idx];
    if (km_we) km_mem[km_wa] <= km_wd;
  end

  always_ff @(posedge clk) begin
    ol_rd <= ol_mem[km_slot];
    if (ol_we) ol_mem[ol_wa] <= ol_wd;
  end

  always_ff @(posedge clk) begin
    nl_rd <= nl_mem[nl_ra];
    if (nl_we) nl_mem[nl_wa] <= nl_wd;
  end

  always_ff @(posedge clk) begin
    ek_rd <= ek_mem[nl_rd];
    if (ent_we) ek_mem[slot_q] <= key_q;
  end

  always_ff @(posedge clk) begin
    ev_rd <= ev_mem[slot_q];
    if (ent_we) ev_mem[slot_q] <= val_q;
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOOKUP: begin
        op_put <= opcode;
        key_q  <= key_idx;
        val_q  <= val_w[VALUE_BITS-1:0];
      end
      OP_DECIDE: begin
        hit_q <= km_hit;
        if (km_hit) slot_q <= km_slot;
        else if (alloc_ok) slot_q <= used[SW-1:0];
      end
      OP_LINK_A:  tail_q <= nl_rd;
      OP_EVICT_A: slot_q <= nl_rd;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      head       <= '0;
      used       <= '0;
      capacity   <= 13'd4096;
      clr_cnt    <= '0;
    end else begin
      if (cfg_valid) capacity <= cfg_data;
      if (cmd.op == OP_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if ((cmd.op == OP_DECIDE) && !km_hit && op_put && alloc_ok &&
          (used != UW'(ENTRIES))) begin
        used <= used + 1'b1;
      end
      if (cmd.op == OP_FINISH) begin
        head       <= slot_q;
        head_valid <= 1'b1;
      end
    end
  end

  assign rv_w       = 32'(ev_rd);
  assign found      = hit_q;
  assign read_value = (!op_put && hit_q) ? rv_w[16:0] : 17'd0;

  `LKV_ASSERT_IMP(a_used_range, 1'b1, used <= UW'(ENTRIES), "used count beyond entry store")
  `LKV_ASSERT_IMP(a_head_used, head_valid, used != '0, "head valid with no slot in use")

endmodule

// ===== design/lru_key_value_cache_unit.sv =====
// Top level of the LRU key-value cache: sequencer plus datapath.
//
// LRU key-value cache. A beat is taken when start is high and busy is low;
// opcode 0 is a get, 1 a put. Exactly one result follows per beat: done is
// high for a single cycle with found and read_value valid in that cycle, and
// the receiver cannot hold it off, so it must take it then. After decide a
// beat reports (get miss) or runs finish, report: directly (hit on the head
// slot, or a put that needs no relinking), after self (first put), evict A/B
// (eviction), link A/B (new key, free slot) or unlink, read tail, link A/B
// (hit elsewhere in the list). busy stays high throughout. The steps follow
// from the link memories: each step of unlinking and relinking the doubly
// linked recency list is a registered read or write of the older/newer link
// arrays, and those steps depend on each other. After reset the key map is
// swept to empty, one entry per cycle, with busy high before the first beat.
// capacity is written over its own valid/ready channel, always ready; write
// it only while no beat is in progress. KEY_SPACE must be a power of two;
// keys are taken modulo KEY_SPACE and values keep their low VALUE_BITS bits.
module lru_key_value_cache_unit #(
  parameter int ENTRIES    = 4096,
  parameter int KEY_SPACE  = 16384,
  parameter int VALUE_BITS = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [13:0] key,
  input  logic [16:0] value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  output logic        done,
  output logic        found,
  output logic [16:0] read_value
);
  import lkv_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // capacity register accepts every write, so the channel is always ready
  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  lkv_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_SPACE  (KEY_SPACE),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .opcode     (opcode),
    .key        (key),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .found      (found),
    .read_value (read_value)
  );

endmodule
